[src/ccr_pkg.sv]
// Package for the contrast ratio core: payload types, controller codes and the sRGB ROM.
`default_nettype none

package ccr_pkg;

   // Parameter defaults
   localparam int RATIO_FRAC_BITS_DEF = 8;
   localparam int COUNT_BITS_DEF      = 16;

   // Fixed field widths
   localparam int CHAN_W      = 8;
   localparam int RATIO_OUT_W = 13;
   localparam int COUNT_OUT_W = 16;
   localparam int THRESH_W    = 13;
   localparam int LIN_W       = 16;
   localparam int ACC_W       = 32;
   localparam int LUM_W       = 16;
   localparam int OFS_W       = 17;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 13'd1152;
   localparam logic [OFS_W-1:0]    LUM_OFFSET   = 17'd3277;

   // Luminance weights, Q0.16
   localparam logic [LIN_W-1:0] W_RED   = 16'd13933;
   localparam logic [LIN_W-1:0] W_GREEN = 16'd46871;
   localparam logic [LIN_W-1:0] W_BLUE  = 16'd4732;

   // Color channel codes for the luminance steps
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // One input item
   typedef struct packed {
      logic [CHAN_W-1:0] fg_red;
      logic [CHAN_W-1:0] fg_green;
      logic [CHAN_W-1:0] fg_blue;
      logic [CHAN_W-1:0] bg_red;
      logic [CHAN_W-1:0] bg_green;
      logic [CHAN_W-1:0] bg_blue;
      logic              start_series;
   } req_type;

   // One result item
   typedef struct packed {
      logic [RATIO_OUT_W-1:0] ratio_q8;
      logic                   below_flag;
      logic [RATIO_OUT_W-1:0] worst_q8;
      logic [COUNT_OUT_W-1:0] below_count;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LUM,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic       lum;
      logic [1:0] ch;
      logic       prep;
      logic       div;
      logic       commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_stall;
   } status_type;

   // Linearization table, built at elaboration
   typedef logic [255:0][LIN_W-1:0] lin_rom_type;

   function automatic lin_rom_type build_lin_rom();
      lin_rom_type rom;
      logic [63:0] e;
      logic [63:0] p;
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] q;
      logic [63:0] t;
      logic [63:0] q2;
      logic [63:0] q4;
      logic [63:0] q5;
      rom = '0;
      for (int c = 0; c < 256; c++) begin
         if (c <= 10) begin
            // linear segment, rounded
            e = (64'(c) * 64'd6553600 + 64'd164730) / 64'd329460;
         end else begin
            p = 64'd40 * 64'(c) + 64'd561;
            r = (p << 32) / 64'd10761;
            if (r > 64'hFFFF_FFFF) begin
               r = 64'hFFFF_FFFF;
            end
            s = (r * r) >> 32;
            q = 64'd0;
            // bitwise search for the fifth root of s
            for (int b = 31; b >= 0; b--) begin
               t  = q | (64'd1 << b);
               q2 = (t * t) >> 32;
               q4 = (q2 * q2) >> 32;
               q5 = (q4 * t) >> 32;
               if (q5 <= s) begin
                  q = t;
               end
            end
            e = (((s * q) >> 32) + 64'd32768) >> 16;
            if (e > 64'd65535) begin
               e = 64'd65535;
            end
         end
         rom[c] = e[LIN_W-1:0];
      end
      return rom;
   endfunction

   localparam lin_rom_type LIN_ROM = build_lin_rom();

endpackage

`default_nettype wire

[src/ccr_ctrl.sv]
// Controller state machine: sequences luminance, divide and commit for one item.
`default_nettype none

module ccr_ctrl
   import ccr_pkg::*;
#(
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam int RATIO_W = RATIO_FRAC_BITS + 5;
   localparam int DCNT_W  = $clog2(RATIO_W);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(RATIO_W - 1);

   state_type         state_ff, state_in;
   logic [1:0]        lum_cnt_ff, lum_cnt_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;

   // State and step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         lum_cnt_ff <= CH_RED;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         lum_cnt_ff <= lum_cnt_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign lum_cnt_in = (state_ff == ST_LUM) ? lum_cnt_ff + 2'd1 : CH_RED;
   assign div_cnt_in = (state_ff == ST_DIV) ? div_cnt_ff + DCNT_W'(1) : '0;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LUM;
         end
         ST_LUM: begin
            if (lum_cnt_ff == CH_BLUE) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == DCNT_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.ch     = lum_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_LUM: begin
            cmd.lum = 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
         end
         ST_DONE: begin
            cmd.commit = !status.out_stall;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/ccr_datapath.sv]
// Datapath: ROM lookup, luminance sums, restoring divider, series state, result register.
`default_nettype none

module ccr_datapath
   import ccr_pkg::*;
#(
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
   parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire req_type             req_data,
   input  wire logic [THRESH_W-1:0] threshold,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_data
);

   localparam int RATIO_W = RATIO_FRAC_BITS + 5;
   localparam logic [RATIO_W-1:0]    WORST_RESET = RATIO_W'(21) << RATIO_FRAC_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

   req_type              item_ff;
   logic [ACC_W-1:0]     acc_fg_ff, acc_fg_in;
   logic [ACC_W-1:0]     acc_bg_ff, acc_bg_in;
   logic [OFS_W-1:0]     rem_ff, rem_in;
   logic [OFS_W-1:0]     den_ff, den_in;
   logic [RATIO_W-1:0]   bits_ff, bits_in;
   logic [RATIO_W-1:0]   quot_ff, quot_in;
   logic [RATIO_W-1:0]   worst_ff, worst_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [CHAN_W-1:0]    fg_code, bg_code;
   logic [LIN_W-1:0]     weight;
   logic [ACC_W-1:0]     prod_fg, prod_bg;
   logic [LUM_W-1:0]     lum_fg, lum_bg, lum_hi, lum_lo;
   logic [OFS_W-1:0]     num_ofs;
   logic [OFS_W:0]       trial;
   logic                 trial_ge;
   logic                 below;
   logic [RATIO_W+THRESH_W-1:0]    ratio_ext, thresh_ext;
   logic [RATIO_W+RATIO_OUT_W-1:0] ratio_wide, worst_wide;
   logic [COUNT_BITS+COUNT_OUT_W-1:0] count_wide;

   assign status.out_stall = rsp_valid_ff && !rsp_ready;

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
   end

   // Channel select and weighted linear values
   always_comb begin
      case (cmd.ch)
         CH_RED: begin
            fg_code = item_ff.fg_red;
            bg_code = item_ff.bg_red;
            weight  = W_RED;
         end
         CH_GREEN: begin
            fg_code = item_ff.fg_green;
            bg_code = item_ff.bg_green;
            weight  = W_GREEN;
         end
         CH_BLUE: begin
            fg_code = item_ff.fg_blue;
            bg_code = item_ff.bg_blue;
            weight  = W_BLUE;
         end
         default: begin
            fg_code = '0;
            bg_code = '0;
            weight  = '0;
         end
      endcase
   end

   assign prod_fg = ACC_W'(LIN_ROM[fg_code]) * ACC_W'(weight);
   assign prod_bg = ACC_W'(LIN_ROM[bg_code]) * ACC_W'(weight);

   // Luminance accumulators, one channel per cycle
   always_comb begin
      acc_fg_in = acc_fg_ff;
      acc_bg_in = acc_bg_ff;
      if (cmd.load) begin
         acc_fg_in = '0;
         acc_bg_in = '0;
      end else if (cmd.lum) begin
         acc_fg_in = acc_fg_ff + prod_fg;
         acc_bg_in = acc_bg_ff + prod_bg;
      end
   end

   always_ff @(posedge clock) begin
      acc_fg_ff <= acc_fg_in;
      acc_bg_ff <= acc_bg_in;
   end

   // Order the luminances and offset them
   assign lum_fg  = acc_fg_ff[ACC_W-1:ACC_W-LUM_W];
   assign lum_bg  = acc_bg_ff[ACC_W-1:ACC_W-LUM_W];
   assign lum_hi  = (lum_fg > lum_bg) ? lum_fg : lum_bg;
   assign lum_lo  = (lum_fg > lum_bg) ? lum_bg : lum_fg;
   assign num_ofs = OFS_W'(lum_hi) + LUM_OFFSET;

   // Restoring divider, one quotient bit per cycle; quotient fits in RATIO_W bits,
   // so the partial remainder starts with the numerator's top bits
   assign trial    = {rem_ff, bits_ff[RATIO_W-1]};
   assign trial_ge = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      if (cmd.prep) begin
         rem_in  = {5'd0, num_ofs[OFS_W-1:5]};
         den_in  = OFS_W'(lum_lo) + LUM_OFFSET;
         bits_in = {num_ofs[4:0], {RATIO_FRAC_BITS{1'b0}}};
         quot_in = '0;
      end else if (cmd.div) begin
         rem_in  = trial_ge ? OFS_W'(trial - {1'b0, den_ff}) : trial[OFS_W-1:0];
         bits_in = bits_ff << 1;
         quot_in = {quot_ff[RATIO_W-2:0], trial_ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   // Series state
   assign ratio_ext  = {{THRESH_W{1'b0}}, quot_ff};
   assign thresh_ext = {{RATIO_W{1'b0}}, threshold};
   assign below      = ratio_ext < thresh_ext;

   always_comb begin
      worst_in = worst_ff;
      count_in = count_ff;
      if (cmd.commit) begin
         if (item_ff.start_series) begin
            worst_in = quot_ff;
            count_in = {{(COUNT_BITS-1){1'b0}}, below};
         end else begin
            if (quot_ff < worst_ff) worst_in = quot_ff;
            if (below && count_ff != COUNT_MAX) count_in = count_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         worst_ff <= WORST_RESET;
         count_ff <= '0;
      end else begin
         worst_ff <= worst_in;
         count_ff <= count_in;
      end
   end

   // Result register
   assign ratio_wide = {{RATIO_OUT_W{1'b0}}, quot_ff};
   assign worst_wide = {{RATIO_OUT_W{1'b0}}, worst_in};
   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.commit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.ratio_q8    = ratio_wide[RATIO_OUT_W-1:0];
         rsp_data_in.below_flag  = below;
         rsp_data_in.worst_q8    = worst_wide[RATIO_OUT_W-1:0];
         rsp_data_in.below_count = count_wide[COUNT_OUT_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[src/color_contrast_ratio_core.sv]
// Top level of the contrast ratio core: register port, controller and datapath.
//
//   port group   direction  handshake              payload
//   req_*        in         req_valid/req_ready    req_type (two colors, start flag)
//   rsp_*        out        rsp_valid/rsp_ready    rsp_type (ratio, flag, worst, count)
//   APB          in         psel/penable/pwrite    threshold register at address 0
//
// From accept to result an item passes an accept step, three luminance steps
// (one channel per cycle), a setup step, the restoring divider (one quotient
// bit per cycle) and a commit step.
// A new item is taken after commit while the previous result may still wait.
// Commit holds while the result register is full and not taken.
// Reset clears control and the count, and sets the threshold to THRESH_RESET and the running minimum to WORST_RESET.
`default_nettype none

module color_contrast_ratio_core
   import ccr_pkg::*;
#(
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
   parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [THRESH_W-1:0] threshold_ff, threshold_in;
   logic                thr_sel;
   cmd_type             cmd;
   status_type          status;

   // Register port
   assign pready  = 1'b1;
   assign thr_sel = (paddr[2] == 1'b0);
   assign prdata  = thr_sel ? {{(32-THRESH_W){1'b0}}, threshold_ff} : 32'd0;

   assign threshold_in = (psel && penable && pwrite && thr_sel)
                       ? pwdata[THRESH_W-1:0] : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // Controller
   ccr_ctrl #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   ccr_datapath #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
      .COUNT_BITS      (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .threshold (threshold_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // Commit never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid && !rsp_ready))
      else $error("result overwritten while held");

   // A commit always presents an item next cycle
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without result");

   // No item is accepted while one is in the divider or committing
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!cmd.div && !cmd.commit && !cmd.lum))
      else $error("item accepted during work");
`endif

endmodule

`default_nettype wire
